// ===== rtl/core/gebm_pkg.sv =====
package gebm_pkg;

  localparam int AxisCodes  = 64;
  localparam int AxisBits   = $clog2(AxisCodes);
  localparam int ValueBits  = 32;
  localparam int ThrWidth   = 2 * ValueBits;
  localparam int InfoWidth  = 7;
  localparam int MaxResults = 6;
  localparam int ResCntBits = 3;

  localparam logic [1:0] OpDeclare    = 2'd0;
  localparam logic [1:0] OpEvent      = 2'd1;
  localparam logic [1:0] OpDisconnect = 2'd2;

  localparam logic [4:0] EvKey  = 5'd1;
  localparam logic [4:0] EvAbs  = 5'd3;

  localparam logic [1:0] ModeButton = 2'd1;
  localparam logic [1:0] ModeTwoway = 2'd2;
  localparam logic [1:0] ModeHat    = 2'd3;

  localparam logic [2:0] BtnUp    = 3'd0;
  localparam logic [2:0] BtnDown  = 3'd1;
  localparam logic [2:0] BtnLeft  = 3'd2;
  localparam logic [2:0] BtnRight = 3'd3;
  localparam logic [2:0] BtnA     = 3'd4;
  localparam logic [2:0] BtnB     = 3'd5;

  localparam logic [9:0] KeyEsc   = 10'd1;
  localparam logic [9:0] KeyUp    = 10'd103;
  localparam logic [9:0] KeyDown  = 10'd108;
  localparam logic [9:0] KeyLeft  = 10'd105;
  localparam logic [9:0] KeyRight = 10'd106;
  localparam logic [9:0] KeyA     = 10'd44;
  localparam logic [9:0] KeyB     = 10'd45;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEmit
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [2:0] button;
    logic       pressed;
  } result_t;

  function automatic logic [3:0] hat_dirs(input logic [2:0] idx);
    logic [3:0] r;
    begin
      unique case (idx)
        3'd0: r = 4'b0001;
        3'd1: r = 4'b1001;
        3'd2: r = 4'b1000;
        3'd3: r = 4'b1010;
        3'd4: r = 4'b0010;
        3'd5: r = 4'b0110;
        3'd6: r = 4'b0100;
        default: r = 4'b0101;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/gebm_ram.sv =====
module gebm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/gebm_declare.sv =====
module gebm_declare (
  input  logic                           clk_i,
  input  logic signed [gebm_pkg::ValueBits-1:0] rest_i,
  input  logic signed [gebm_pkg::ValueBits-1:0] min_i,
  input  logic signed [gebm_pkg::ValueBits-1:0] max_i,
  input  logic [gebm_pkg::AxisBits-1:0]  code_i,
  output logic                           keep_o,
  output logic [gebm_pkg::ThrWidth-1:0]  thr_o,
  output logic [gebm_pkg::InfoWidth-1:0] info_o
);
  import gebm_pkg::*;

  localparam int W = ValueBits + 1;

  logic signed [W-1:0] mn, mx, rs, sum, mid, lo, hi, lo2, hi2;
  logic signed [W-1:0] mid_q, mn_q, mx_q;
  logic                two_q, btn_q, hat_q, vert_q, odd_q;
  logic                two_d, btn_d, hat_d, vert_d;

  always_comb begin
    mn  = W'(min_i);
    mx  = W'(max_i);
    rs  = W'(rest_i);
    sum = mn + mx;
    two_d = (rs > mn) && (rs < mx);
    btn_d = (mx >= mn + 1) && (rs == mn);
    hat_d = (mx == mn + 7);
    if (code_i == AxisBits'(3)) begin
      vert_d = 1'b0;
    end else if (code_i == AxisBits'(4)) begin
      vert_d = 1'b1;
    end else begin
      vert_d = code_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q  <= sum >>> 1;
    mn_q   <= mn;
    mx_q   <= mx;
    two_q  <= two_d;
    btn_q  <= btn_d;
    hat_q  <= hat_d;
    vert_q <= vert_d;
    odd_q  <= code_i[0];
  end

  always_comb begin
    mid = mid_q;
    lo  = (mn_q + mid) >>> 1;
    hi  = (mx_q + mid) >>> 1;
    lo2 = (lo >= mid) ? mid - 1 : lo;
    hi2 = (hi <= mid) ? mid + 1 : hi;
    keep_o = two_q | btn_q | hat_q;
    if (two_q) begin
      thr_o  = {hi2[ValueBits-1:0], lo2[ValueBits-1:0]};
      info_o = {4'b0000, vert_q, ModeTwoway};
    end else if (btn_q) begin
      thr_o  = {mid[ValueBits-1:0], {ValueBits{1'b0}}};
      info_o = {4'b0000, odd_q, ModeButton};
    end else begin
      thr_o  = {{ValueBits{1'b0}}, mn_q[ValueBits-1:0]};
      info_o = {4'b1111, 1'b0, ModeHat};
    end
  end
endmodule

// ===== rtl/core/gamepad_event_to_button_mapper.sv =====
// an item is accepted in StIdle, read and decided in StRead, then sent in StEmit
// no new item is taken until every result beat of the last one is sent
// the axis tables are single-port-write rams, read out in the cycle after accept
// reset clears held buttons, axis present bits and control; the rams are not cleared
// an entry is only used while its present bit is set
module gamepad_event_to_button_mapper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   operation_i,
  input  logic [4:0]   event_type_i,
  input  logic [9:0]   code_i,
  input  logic [31:0]  value_i,
  input  logic [31:0]  range_min_i,
  input  logic [31:0]  range_max_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         kind_o,
  output logic [2:0]   button_o,
  output logic         pressed_o,
  output logic         last_o
);
  import gebm_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  op_q;
  logic [4:0]  typ_q;
  logic [9:0]  code_q;
  logic signed [ValueBits-1:0] val_q;
  logic [5:0]  held_q, held_d;
  logic [AxisCodes-1:0] pres_q, pres_d;
  logic [ThrWidth-1:0]  thr_rd, thr_wd;
  logic [InfoWidth-1:0] info_rd, info_wd;
  logic thr_we, info_we;
  logic keep;
  logic [ThrWidth-1:0]  dthr;
  logic [InfoWidth-1:0] dinfo;
  result_t res_d [MaxResults];
  result_t res_q [MaxResults];
  logic [ResCntBits-1:0] cnt_d, cnt_q, idx_q;
  logic accept;
  logic [AxisBits-1:0] axis;
  logic axis_ok;

  assign accept  = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign axis    = code_q[AxisBits-1:0];
  assign axis_ok = (code_q < 10'(AxisCodes));

  gebm_ram #(.Width(ThrWidth), .Depth(AxisCodes)) u_thr (
    .clk_i, .we_i(thr_we), .waddr_i(axis), .wdata_i(thr_wd),
    .raddr_i(code_i[AxisBits-1:0]), .rdata_o(thr_rd));
  gebm_ram #(.Width(InfoWidth), .Depth(AxisCodes)) u_info (
    .clk_i, .we_i(info_we), .waddr_i(axis), .wdata_i(info_wd),
    .raddr_i(code_i[AxisBits-1:0]), .rdata_o(info_rd));

  gebm_declare u_decl (
    .clk_i, .rest_i(value_i[ValueBits-1:0]), .min_i(range_min_i[ValueBits-1:0]),
    .max_i(range_max_i[ValueBits-1:0]), .code_i(code_i[AxisBits-1:0]),
    .keep_o(keep), .thr_o(dthr), .info_o(dinfo));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      typ_q  <= event_type_i;
      code_q <= code_i;
      val_q  <= value_i[ValueBits-1:0];
    end
    if (state_q == StRead) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpDisconnect;
      held_q  <= '0;
      pres_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) op_q <= operation_i;
      held_q  <= held_d;
      pres_q  <= pres_d;
      if (state_q == StRead) begin
        cnt_q <= cnt_d;
        idx_q <= '0;
      end else if (out_valid_o && out_ready_i) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StRead;
      StRead: state_d = (cnt_d == '0) ? StIdle : StEmit;
      StEmit: if (out_ready_i && (idx_q + 1'b1 == cnt_q)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // item decision
  always_comb begin
    logic [1:0] mode;
    logic sel, btn_found, cur;
    logic signed [3:0] old, v;
    logic signed [ValueBits-1:0] lo, hi;
    logic signed [ValueBits:0] d;
    logic [2:0] b, neg, pos;
    logic [3:0] nst, ost;
    held_d  = held_q;
    pres_d  = pres_q;
    cnt_d   = '0;
    thr_we  = 1'b0;
    info_we = 1'b0;
    thr_wd  = dthr;
    info_wd = dinfo;
    mode = info_rd[1:0];
    sel  = info_rd[2];
    old  = info_rd[6:3];
    lo   = thr_rd[ValueBits-1:0];
    hi   = thr_rd[ThrWidth-1:ValueBits];
    v    = old;
    b    = BtnA;
    btn_found = 1'b1;
    neg = sel ? BtnUp : BtnLeft;
    pos = sel ? BtnDown : BtnRight;
    d   = (ValueBits+1)'(val_q) - (ValueBits+1)'(lo);
    nst = '0;
    ost = held_q[3:0];
    cur = 1'b0;
    for (int i = 0; i < MaxResults; i++) res_d[i] = '0;
    if (state_q == StRead) begin
      unique case (op_q)
        OpDeclare: begin
          if (axis_ok) begin
            pres_d[axis] = keep;
            thr_we  = keep;
            info_we = keep;
          end
        end
        OpEvent: begin
          if (typ_q == EvKey) begin
            unique case (code_q)
              KeyEsc:   btn_found = 1'b0;
              KeyUp:    b = BtnUp;
              KeyDown:  b = BtnDown;
              KeyLeft:  b = BtnLeft;
              KeyRight: b = BtnRight;
              KeyA:     b = BtnA;
              KeyB:     b = BtnB;
              default: begin
                btn_found = (code_q >= 10'h100);
                b = code_q[0] ? BtnB : BtnA;
              end
            endcase
            cur = held_q[b];
            if (code_q == KeyEsc) begin
              res_d[0] = '{kind: 1'b1, button: 3'd0, pressed: 1'b0};
              cnt_d = 3'd1;
            end else if (btn_found && ((val_q != '0) != cur)) begin
              held_d[b] = (val_q != '0);
              res_d[0] = '{kind: 1'b0, button: b, pressed: (val_q != '0)};
              cnt_d = 3'd1;
            end
          end else if (typ_q == EvAbs && axis_ok && pres_q[axis]) begin
            unique case (mode)
              ModeButton: begin
                v = (val_q >= hi) ? 4'sd1 : 4'sd0;
                if (v != old) begin
                  b = sel ? BtnA : BtnB;
                  held_d[b] = v[0];
                  res_d[0] = '{kind: 1'b0, button: b, pressed: v[0]};
                  cnt_d = 3'd1;
                end
              end
              ModeTwoway: begin
                v = (val_q <= lo) ? -4'sd1 : ((val_q >= hi) ? 4'sd1 : 4'sd0);
                if (v != old) begin
                  if (v <= 0 && held_d[pos]) begin
                    held_d[pos] = 1'b0;
                    res_d[cnt_d] = '{kind: 1'b0, button: pos, pressed: 1'b0};
                    cnt_d = cnt_d + 1'b1;
                  end
                  if (v >= 0 && held_d[neg]) begin
                    held_d[neg] = 1'b0;
                    res_d[cnt_d] = '{kind: 1'b0, button: neg, pressed: 1'b0};
                    cnt_d = cnt_d + 1'b1;
                  end
                  if (v < 0 && !held_d[neg]) begin
                    held_d[neg] = 1'b1;
                    res_d[cnt_d] = '{kind: 1'b0, button: neg, pressed: 1'b1};
                    cnt_d = cnt_d + 1'b1;
                  end
                  if (v > 0 && !held_d[pos]) begin
                    held_d[pos] = 1'b1;
                    res_d[cnt_d] = '{kind: 1'b0, button: pos, pressed: 1'b1};
                    cnt_d = cnt_d + 1'b1;
                  end
                end
              end
              ModeHat: begin
                v = (d < 0 || d >= 8) ? -4'sd1 : {1'b0, d[2:0]};
                if (v != old) begin
                  nst = (v < 0) ? 4'b0000 : hat_dirs(v[2:0]);
                  held_d[3:0] = nst;
                  for (int k = 0; k < 4; k++) begin
                    if (nst[k] != ost[k]) begin
                      res_d[cnt_d] = '{kind: 1'b0, button: 3'(k), pressed: nst[k]};
                      cnt_d = cnt_d + 1'b1;
                    end
                  end
                end
              end
              default: v = old;
            endcase
            if (v != old && (mode inside {ModeButton, ModeTwoway, ModeHat})) begin
              info_we = 1'b1;
              thr_we  = 1'b0;
              info_wd = {v, sel, mode};
            end
          end
        end
        OpDisconnect: begin
          for (int k = 5; k >= 0; k--) begin
            if (held_q[k]) begin
              res_d[cnt_d] = '{kind: 1'b0, button: 3'(k), pressed: 1'b0};
              cnt_d = cnt_d + 1'b1;
            end
          end
          held_d = '0;
          pres_d = '0;
        end
        default: cnt_d = '0;
      endcase
    end
  end

  always_comb begin
    result_t r;
    r = res_q[idx_q];
    out_valid_o = (state_q == StEmit);
    kind_o      = r.kind;
    button_o    = r.button;
    pressed_o   = r.pressed;
    last_o      = (idx_q + 1'b1 == cnt_q);
  end
endmodule

// ===== rtl/core/gebm_checker.sv =====
module gebm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       kind_o,
  input logic [2:0] button_o,
  input logic       pressed_o,
  input logic       last_o
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during results");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("input taken back to back");
  a_button_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (button_o <= 3'd5)) else $error("button out of range");
  a_quit_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (last_o && !pressed_o && button_o == 3'd0))
    else $error("quit beat malformed");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(button_o)))
    else $error("result dropped");
endmodule

bind gamepad_event_to_button_mapper gebm_checker u_gebm_checker (.*);
